// ===== rtl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, codes and the control program of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

	// Index counters are 3 bits wide, holding indices 0 to 7
	localparam int IDX_W = 3;

	// Result value width
	localparam int PROD_W = 34;

	// Dimension register
	localparam int DIM_W = 3;
	localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

	// Input kinds
	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_START  = 2'd2;

	// Program steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
	localparam logic [STEP_W-1:0] STEP_READ  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_MUL   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_ACC   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;

	// Sequencing modes of a control word
	typedef enum logic [1:0] {
		JMP_NEXT,   // go to the following step
		JMP_FETCH,  // on a start request go to target, else stay
		JMP_KLOOP,  // while k is not last go to target, else fall through
		JMP_EMIT    // hold while output is full; then target or back to fetch
	} jmp_t;

	// One control word
	typedef struct packed {
		logic              ready;
		logic              rd;
		logic              mul;
		logic              acc;
		logic              emit;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} ucode_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic [1:0]       wr_row;
		logic [1:0]       wr_col;
		logic             rd;
		logic             mul;
		logic             acc;
		logic             acc_first;
		logic             emit;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
		logic             last;
	} ctrl_t;

	// Control program ROM
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{ready: 1'b1, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
		      jmp: JMP_FETCH, target: STEP_READ};
		unique case (step)
			STEP_FETCH: w = '{ready: 1'b1, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
			                  jmp: JMP_FETCH, target: STEP_READ};
			STEP_READ:  w = '{ready: 1'b0, rd: 1'b1, mul: 1'b0, acc: 1'b0, emit: 1'b0,
			                  jmp: JMP_NEXT, target: STEP_MUL};
			STEP_MUL:   w = '{ready: 1'b0, rd: 1'b0, mul: 1'b1, acc: 1'b0, emit: 1'b0,
			                  jmp: JMP_NEXT, target: STEP_ACC};
			STEP_ACC:   w = '{ready: 1'b0, rd: 1'b0, mul: 1'b0, acc: 1'b1, emit: 1'b0,
			                  jmp: JMP_KLOOP, target: STEP_READ};
			STEP_EMIT:  w = '{ready: 1'b0, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b1,
			                  jmp: JMP_EMIT, target: STEP_READ};
			default:    w = '{ready: 1'b1, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
			                  jmp: JMP_FETCH, target: STEP_READ};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/mme_seq.sv =====
// ----------------------------------------------------------------------------
// mme_seq
// Microcoded sequencer: step counter, control ROM, loop counters and the
// dimension register.
// ----------------------------------------------------------------------------
module mme_seq import mme_pkg::*; #(
	parameter int MAX_DIM = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	// input request fields
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_kind,
	input  logic [1:0]       in_row,
	input  logic [1:0]       in_col,
	// dimension write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [DIM_W-1:0] cfg_data,
	// datapath
	input  logic             out_free,
	output ctrl_t            ctrl
);

	logic [STEP_W-1:0] step_q, step_nxt;
	logic [DIM_W-1:0]  dim_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [3:0]        dim_eff;
	logic [IDX_W-1:0]  last_idx;
	ucode_t            w;
	logic              fire, start, in_range, emit_fire;
	logic              i_last, j_last, k_last;

	assign cfg_ready = 1'b1;

	// Effective dimension, saturated to 1..MAX_DIM
	always_comb begin
		if (dim_q == '0) begin
			dim_eff = 4'd1;
		end else if (32'(dim_q) > MAX_DIM) begin
			dim_eff = 4'(MAX_DIM);
		end else begin
			dim_eff = 4'(dim_q);
		end
	end
	assign last_idx = IDX_W'(dim_eff - 4'd1);

	assign w         = ucode_rom(step_q);
	assign in_ready  = w.ready;
	assign fire      = in_valid & w.ready;
	assign start     = fire && (in_kind == KIND_START);
	assign in_range  = ({2'b00, in_row} < dim_eff) && ({2'b00, in_col} < dim_eff);
	assign i_last    = (i_q == last_idx);
	assign j_last    = (j_q == last_idx);
	assign k_last    = (k_q == last_idx);
	assign emit_fire = w.emit & out_free;

	// Next step
	always_comb begin
		step_nxt = step_q;
		unique case (w.jmp)
			JMP_NEXT:  step_nxt = step_q + 3'd1;
			JMP_FETCH: step_nxt = start ? w.target : step_q;
			JMP_KLOOP: step_nxt = k_last ? step_q + 3'd1 : w.target;
			JMP_EMIT: begin
				if (out_free) begin
					step_nxt = (i_last && j_last) ? STEP_FETCH : w.target;
				end
			end
			default:   step_nxt = STEP_FETCH;
		endcase
	end

	// Step counter, loop counters, dimension register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
			dim_q  <= DIM_RESET;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
		end else begin
			step_q <= step_nxt;
			if (cfg_valid) begin
				dim_q <= cfg_data;
			end
			if (start) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (w.acc && !k_last) begin
				k_q <= k_q + 1'b1;
			end else if (emit_fire) begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	// Datapath controls
	always_comb begin
		ctrl.wr_a      = fire && (in_kind == KIND_LOAD_A) && in_range;
		ctrl.wr_b      = fire && (in_kind == KIND_LOAD_B) && in_range;
		ctrl.wr_row    = in_row;
		ctrl.wr_col    = in_col;
		ctrl.rd        = w.rd;
		ctrl.mul       = w.mul;
		ctrl.acc       = w.acc;
		ctrl.acc_first = (k_q == '0);
		ctrl.emit      = emit_fire;
		ctrl.i         = i_q;
		ctrl.j         = j_q;
		ctrl.k         = k_q;
		ctrl.last      = i_last && j_last;
	end

endmodule

// ===== rtl/mme_datapath.sv =====
// ----------------------------------------------------------------------------
// mme_datapath
// Element stores for A and B, multiplier, accumulator and output register.
// ----------------------------------------------------------------------------
module mme_datapath import mme_pkg::*; #(
	parameter int MAX_DIM = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	input  logic signed [15:0]       wr_value,
	output logic                     out_free,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               out_row,
	output logic [1:0]               out_col,
	output logic signed [PROD_W-1:0] out_value,
	output logic                     out_last
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic signed [15:0]       mem_a [CELLS];
	logic signed [15:0]       mem_b [CELLS];
	logic [AW-1:0]            wr_addr, ra_addr, rb_addr;
	logic signed [15:0]       rd_a_q, rd_b_q;
	logic signed [31:0]       prod_q;
	logic signed [PROD_W-1:0] acc_q;
	logic                     out_valid_q;

	// Row-major addresses
	assign wr_addr = AW'(32'(ctrl.wr_row) * MAX_DIM + 32'(ctrl.wr_col));
	assign ra_addr = AW'(32'(ctrl.i) * MAX_DIM + 32'(ctrl.k));
	assign rb_addr = AW'(32'(ctrl.k) * MAX_DIM + 32'(ctrl.j));

	// Store A
	always_ff @(posedge clk) begin
		if (ctrl.wr_a) begin
			mem_a[wr_addr] <= wr_value;
		end
		if (ctrl.rd) begin
			rd_a_q <= mem_a[ra_addr];
		end
	end

	// Store B
	always_ff @(posedge clk) begin
		if (ctrl.wr_b) begin
			mem_b[wr_addr] <= wr_value;
		end
		if (ctrl.rd) begin
			rd_b_q <= mem_b[rb_addr];
		end
	end

	// Multiply, then accumulate; first term of a sum loads the accumulator
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= rd_a_q * rd_b_q;
		end
		if (ctrl.acc) begin
			if (ctrl.acc_first) begin
				acc_q <= PROD_W'(prod_q);
			end else begin
				acc_q <= acc_q + PROD_W'(prod_q);
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_row   <= 2'(ctrl.i);
			out_col   <= 2'(ctrl.j);
			out_value <= acc_q;
			out_last  <= ctrl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Load items fill A and B one element per cycle while the engine waits in its
// fetch step; a start request streams C = A x B out in row-major order with
// the final element flagged. Each product element is built by a read, multiply
// and add step per term through the single MAC unit, then one emit step; a start
// request occupies the engine until all n*n elements are out, plus any stall.
// Throughput: one load request per cycle while the engine is idle.
// Reset: clears the sequencer, loop counters and output valid, sets the
// dimension to 4; the element stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine import mme_pkg::*; #(
	parameter int MAX_DIM = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	// input requests
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,   // row_index[1:0], col_index[3:2], element_value[19:4]
	input  logic [1:0]       s_tuser,   // kind[1:0]
	// product elements
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // out_row[1:0], out_col[3:2], product_value[37:4]
	output logic             m_tlast,   // last_element
	// dimension register
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [DIM_W-1:0] cfg_data   // dim_in_use
);

	ctrl_t                    ctrl;
	logic                     out_free;
	logic [1:0]               out_row, out_col;
	logic signed [PROD_W-1:0] out_value;

	mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_row    (s_tdata[1:0]),
		.in_col    (s_tdata[3:2]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	mme_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.wr_value  (s_tdata[19:4]),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.out_last  (m_tlast)
	);

	// Pack result fields, lowest first, padded to whole bytes
	assign m_tdata = {2'b00, out_value, out_col, out_row};

endmodule

// ===== tb/sv/matrix_multiply_engine_test.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_test
// Self-checking bench for the matrix multiply engine. Load and start requests
// are streamed in with random idle bursts on both sides. A behavioral copy of
// the A and B stores predicts every product element, which is matched in
// order against the output stream. The dimension is changed between phases
// while the engine is idle.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_test import mme_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_MAX = 4;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE = 8;        // settle time after the output stream drains
	localparam int TAIL = 250;        // longer than one full 4x4 run
	localparam int ITEM_GOAL = 330;
	localparam int QUIET_FROM = 290;  // no idling from here on
	localparam logic [15:0] MOST_NEG = 16'h8000;
	localparam logic [15:0] MOST_POS = 16'h7fff;

	// one product element
	typedef struct packed {
		logic [1:0]        row;
		logic [1:0]        col;
		logic [PROD_W-1:0] value;
		logic              last;
	} elem_t;

	// Predicts product elements from the requests the engine accepts
	class product_tracker;
		logic signed [15:0] a_mat [N_MAX][N_MAX];
		logic signed [15:0] b_mat [N_MAX][N_MAX];
		logic [DIM_W-1:0]   dim_reg;
		elem_t              expected_q [$];
		int                 errors;

		function new();
			dim_reg = DIM_RESET;
			errors = 0;
			foreach (a_mat[i, j]) begin
				a_mat[i][j] = '0;
				b_mat[i][j] = '0;
			end
		endfunction

		// zero acts as one, large values saturate
		function int eff_dim();
			if (dim_reg == 0)
				return 1;
			if (int'(dim_reg) > N_MAX)
				return N_MAX;
			return int'(dim_reg);
		endfunction

		function void write_dim(logic [DIM_W-1:0] v);
			dim_reg = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(logic [1:0] kind, logic [1:0] row, logic [1:0] col,
		                           logic [15:0] val);
			int n;
			logic signed [63:0] acc;
			elem_t e;
			n = eff_dim();
			if (kind == KIND_LOAD_A || kind == KIND_LOAD_B) begin
				// loads outside the active square are dropped
				if (int'(row) < n && int'(col) < n) begin
					if (kind == KIND_LOAD_A)
						a_mat[row][col] = val;
					else
						b_mat[row][col] = val;
				end
			end else if (kind == KIND_START) begin
				for (int i = 0; i < n; i++) begin
					for (int j = 0; j < n; j++) begin
						acc = '0;
						for (int k = 0; k < n; k++)
							acc += 64'(a_mat[i][k]) * 64'(b_mat[k][j]);
						e.row = 2'(i);
						e.col = 2'(j);
						e.value = acc[PROD_W-1:0];
						e.last = (i == n - 1) && (j == n - 1);
						expected_q.push_back(e);
					end
				end
			end
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h",
			         $realtime, what, got, want);
			errors++;
		endtask

		task check_element(logic [1:0] row, logic [1:0] col, logic [PROD_W-1:0] value,
		                   logic last);
			elem_t e;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected element", 64'({row, col}), 64'(0));
				return;
			end
			e = expected_q.pop_front();
			if (row !== e.row)
				report_mismatch("out_row", 64'(row), 64'(e.row));
			if (col !== e.col)
				report_mismatch("out_col", 64'(col), 64'(e.col));
			if (value !== e.value)
				report_mismatch("product_value", 64'(value), 64'(e.value));
			if (last !== e.last)
				report_mismatch("last_element", 64'(last), 64'(e.last));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [23:0]      s_tdata;   // row_index[1:0], col_index[3:2], element_value[19:4]
	logic [1:0]       s_tuser;   // kind[1:0]
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [39:0]      m_tdata;   // out_row[1:0], out_col[3:2], product_value[37:4]
	logic             m_tlast;   // last_element
	logic             cfg_valid;
	logic             cfg_ready;
	logic [DIM_W-1:0] cfg_data;  // dim_in_use

	product_tracker sb;
	bit loaded_a [N_MAX][N_MAX];
	bit loaded_b [N_MAX][N_MAX];
	int drv_n;
	int item_count;
	bit idle_on;
	int hold_left = 0;

	matrix_multiply_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// output side back-pressure in bursts
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			hold_left <= $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watch all three channels
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tuser, s_tdata[1:0], s_tdata[3:2], s_tdata[19:4]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_element(m_tdata[1:0], m_tdata[3:2], m_tdata[37:4], m_tlast);
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_dim(cfg_data);
	end

	function automatic logic [15:0] rand_element();
		case ($urandom_range(0, 7))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// one request, optionally preceded by an idle burst
	task automatic send_item(logic [1:0] kind, logic [1:0] row, logic [1:0] col,
	                         logic [15:0] val);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0000, val, col, row};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_element(logic [1:0] kind, int row, int col, logic [15:0] val);
		send_item(kind, 2'(row), 2'(col), val);
		if (row < drv_n && col < drv_n) begin
			if (kind == KIND_LOAD_A)
				loaded_a[row][col] = 1'b1;
			else
				loaded_b[row][col] = 1'b1;
			item_count++;
		end
	endtask

	task automatic fill_matrices();
		for (int i = 0; i < drv_n; i++)
			for (int j = 0; j < drv_n; j++) begin
				load_element(KIND_LOAD_A, i, j, rand_element());
				load_element(KIND_LOAD_B, i, j, rand_element());
			end
	endtask

	// every entry a run reads must hold a written value
	task automatic start_multiply();
		for (int i = 0; i < drv_n; i++)
			for (int j = 0; j < drv_n; j++) begin
				if (!loaded_a[i][j])
					load_element(KIND_LOAD_A, i, j, rand_element());
				if (!loaded_b[i][j])
					load_element(KIND_LOAD_B, i, j, rand_element());
			end
		send_item(KIND_START, 2'($urandom), 2'($urandom), 16'($urandom));
		item_count++;
	endtask

	// requests the engine drops: unused kind or a load outside the square
	task automatic send_noise();
		if (drv_n < N_MAX && $urandom_range(0, 1) == 0) begin
			if ($urandom_range(0, 1) == 0)
				load_element(2'($urandom_range(0, 1)), $urandom_range(drv_n, N_MAX - 1),
				             $urandom_range(0, N_MAX - 1), rand_element());
			else
				load_element(2'($urandom_range(0, 1)), $urandom_range(0, N_MAX - 1),
				             $urandom_range(drv_n, N_MAX - 1), rand_element());
		end else begin
			send_item(KIND_UNUSED, 2'($urandom), 2'($urandom), 16'($urandom));
		end
	endtask

	// hold off until every product element has come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_dim(logic [DIM_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		drv_n = sb.eff_dim();
	endtask

	initial begin
		int plan [8];
		int phase;
		logic [DIM_W-1:0] v;
		plan = '{2, 4, 3, 6, 1, 5, 0, 7};
		phase = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_on = 1'b0;
		item_count = 0;
		drv_n = N_MAX;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// 1x1: most negative squared, dropped loads, unused kind
		set_dim(DIM_W'(1));
		load_element(KIND_LOAD_A, 0, 0, MOST_NEG);
		load_element(KIND_LOAD_B, 0, 0, MOST_NEG);
		send_item(KIND_UNUSED, 2'd3, 2'd3, 16'hffff);
		load_element(KIND_LOAD_A, 1, 0, MOST_POS);
		load_element(KIND_LOAD_B, 0, 3, MOST_POS);
		start_multiply();
		load_element(KIND_LOAD_A, 0, 0, MOST_POS);
		start_multiply();
		wait_idle();

		// zero dimension behaves as one
		set_dim(DIM_W'(0));
		load_element(KIND_LOAD_B, 0, 0, MOST_POS);
		start_multiply();
		wait_idle();

		// saturated dimension, largest and smallest sums
		set_dim(DIM_W'(7));
		for (int i = 0; i < N_MAX; i++)
			for (int j = 0; j < N_MAX; j++) begin
				load_element(KIND_LOAD_A, i, j, MOST_NEG);
				load_element(KIND_LOAD_B, i, j, MOST_NEG);
			end
		start_multiply();
		for (int i = 0; i < N_MAX; i++)
			load_element(KIND_LOAD_B, i, 0, MOST_POS);
		start_multiply();
		wait_idle();

		// random phases, each under its own dimension
		while (item_count < ITEM_GOAL) begin
			if (phase < 8)
				v = DIM_W'(plan[phase]);
			else if ($urandom_range(0, 3) == 0)
				v = DIM_W'($urandom_range(0, 7));
			else
				v = DIM_W'($urandom_range(1, 3));
			set_dim(v);
			idle_on = (item_count < QUIET_FROM) && ($urandom_range(0, 4) != 0);
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 9) < 4)
					fill_matrices();
				else
					repeat ($urandom_range(1, 4))
						load_element(2'($urandom_range(0, 1)), $urandom_range(0, drv_n - 1),
						             $urandom_range(0, drv_n - 1), rand_element());
				if ($urandom_range(0, 3) == 0)
					send_noise();
				start_multiply();
			end
			wait_idle();
			phase++;
		end

		idle_on = 1'b0;
		wait_idle();
		repeat (TAIL) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch("elements never produced", 64'(0), 64'(sb.pending()));
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
